### design/mnst_pkg.sv
`default_nettype none
package mnst_pkg;

  typedef enum logic [2:0] {
    OP_NOTE_ON      = 3'd0,
    OP_NOTE_OFF     = 3'd1,
    OP_SUSTAIN      = 3'd2,
    OP_CLEAR_SOURCE = 3'd3,
    OP_CLEAR_SAMPLE = 3'd4,
    OP_RESET_ALL    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    KIND_DONE    = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_DROP    = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_PLACE = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  localparam logic [7:0] NO_VOICE = 8'd255;

endpackage
`default_nettype wire

### design/midi_note_slot_table_core.sv
`default_nettype none
// Note slot table with per-source, per-channel sustain flags. A request is taken when start_i
// is high and busy_o is low; the block then walks the slot table one slot per clock, reporting
// each released or dropped slot on a one-cycle valid_o strobe, and ends every request with a
// done item (last_o high). A note_on that scans goes on from the scan to a place step, where
// it takes a free slot or evicts the slot at the replace pointer; the other ops go to the done
// step, and busy_o stays high until then. The scan counter walks the single slot read port.
// Results cannot be stalled: the receiver must take every strobe.
module midi_note_slot_table_core #(
  parameter int SLOT_COUNT         = 16,
  parameter int SOURCE_COUNT       = 7,
  parameter int CHANNEL_COUNT      = 16,
  parameter int SAMPLE_VOICE_COUNT = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [2:0]  source_num_i,
  input  wire logic [3:0]  channel_i,
  input  wire logic [6:0]  note_i,
  input  wire logic [7:0]  pad_voice_i,
  input  wire logic [7:0]  lead_voice_i,
  input  wire logic [7:0]  sample_voice_i,
  input  wire logic [15:0] owner_tag_i,
  input  wire logic        transient_flag_i,
  input  wire logic        pedal_down_i,
  output logic             valid_o,
  output logic [1:0]       kind_o,
  output logic [2:0]       out_source_o,
  output logic [7:0]       out_pad_voice_o,
  output logic [7:0]       out_lead_voice_o,
  output logic [7:0]       out_sample_voice_o,
  output logic             out_transient_o,
  output logic             last_o
);

  localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SRC_W = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
  localparam int CH_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  mnst_pkg::state_e state_q, state_d;

  logic [SLOT_COUNT-1:0] sl_act_q, sl_sus_q;
  logic                  sl_tr_q   [SLOT_COUNT];
  logic [2:0]            sl_src_q  [SLOT_COUNT];
  logic [3:0]            sl_ch_q   [SLOT_COUNT];
  logic [6:0]            sl_note_q [SLOT_COUNT];
  logic [15:0]           sl_own_q  [SLOT_COUNT];
  logic [7:0]            sl_pad_q  [SLOT_COUNT];
  logic [7:0]            sl_lead_q [SLOT_COUNT];
  logic [7:0]            sl_smp_q  [SLOT_COUNT];

  logic [CHANNEL_COUNT-1:0] flags_q [SOURCE_COUNT];
  logic [SW-1:0]     ptr_q, idx_q, free_idx_q, rd_idx;
  logic              free_found_q, held_q;

  logic [2:0]  op_q, src_q;
  logic [3:0]  ch_q;
  logic [6:0]  note_q;
  logic [7:0]  pad_q, lead_q, smp_q;
  logic [15:0] own_q;
  logic        tr_q;

  logic        valid_q, tr_out_q, last_q;
  logic [1:0]  kind_q;
  logic [2:0]  src_out_q;
  logic [7:0]  pad_out_q, lead_out_q, smp_out_q;

  logic              accept, src_ok, ch_ok, in_valid, flag_cur, scan_en;
  logic [SRC_W-1:0]  flag_src;
  logic [CH_W-1:0]   flag_ch;
  logic              hit, emit, last_idx;
  logic [1:0]        hit_kind;

  assign accept   = start_i && (state_q == mnst_pkg::S_IDLE);
  assign busy_o   = (state_q != mnst_pkg::S_IDLE);
  assign src_ok   = (source_num_i != 3'd0) && ({1'b0, source_num_i} <= 4'(SOURCE_COUNT));
  assign ch_ok    = ({1'b0, channel_i} < 5'(CHANNEL_COUNT));
  assign in_valid = src_ok && ch_ok;
  assign flag_src = SRC_W'(source_num_i - 3'd1);
  assign flag_ch  = CH_W'(channel_i);
  assign flag_cur = in_valid ? flags_q[flag_src][flag_ch] : 1'b0;
  assign rd_idx   = (state_q == mnst_pkg::S_PLACE) ? ptr_q : idx_q;
  assign last_idx = (idx_q == SW'(SLOT_COUNT - 1));

  always_comb begin
    scan_en = 1'b0;
    unique case (op_i)
      mnst_pkg::OP_NOTE_ON: begin
        scan_en = in_valid && !(pad_voice_i == mnst_pkg::NO_VOICE &&
                  lead_voice_i == mnst_pkg::NO_VOICE && sample_voice_i == mnst_pkg::NO_VOICE);
      end
      mnst_pkg::OP_NOTE_OFF: scan_en = in_valid;
      mnst_pkg::OP_SUSTAIN: scan_en = in_valid && flag_cur && !pedal_down_i;
      mnst_pkg::OP_CLEAR_SOURCE: scan_en = 1'b1;
      mnst_pkg::OP_CLEAR_SAMPLE: scan_en = ({1'b0, sample_voice_i} < 9'(SAMPLE_VOICE_COUNT));
      default: scan_en = 1'b0;
    endcase
  end

  always_comb begin
    hit      = 1'b0;
    hit_kind = mnst_pkg::KIND_DROP;
    unique case (op_q)
      mnst_pkg::OP_NOTE_ON: begin
        hit = sl_act_q[rd_idx] && sl_src_q[rd_idx] == src_q &&
              ((pad_q != mnst_pkg::NO_VOICE && sl_pad_q[rd_idx] == pad_q) ||
               (lead_q != mnst_pkg::NO_VOICE && sl_lead_q[rd_idx] == lead_q) ||
               (smp_q != mnst_pkg::NO_VOICE && sl_smp_q[rd_idx] == smp_q));
      end
      mnst_pkg::OP_NOTE_OFF: begin
        hit = sl_act_q[rd_idx] && sl_src_q[rd_idx] == src_q && sl_ch_q[rd_idx] == ch_q &&
              sl_note_q[rd_idx] == note_q && (own_q == 16'd0 || sl_own_q[rd_idx] == own_q);
        hit_kind = mnst_pkg::KIND_RELEASE;
      end
      mnst_pkg::OP_SUSTAIN: begin
        hit = sl_act_q[rd_idx] && sl_sus_q[rd_idx] && sl_src_q[rd_idx] == src_q &&
              sl_ch_q[rd_idx] == ch_q;
        hit_kind = mnst_pkg::KIND_RELEASE;
      end
      mnst_pkg::OP_CLEAR_SOURCE: begin
        hit = sl_act_q[rd_idx] && (src_q == 3'd0 || sl_src_q[rd_idx] == src_q);
      end
      mnst_pkg::OP_CLEAR_SAMPLE: hit = sl_act_q[rd_idx] && sl_smp_q[rd_idx] == smp_q;
      default: hit = 1'b0;
    endcase
    emit = hit && !(op_q == mnst_pkg::OP_NOTE_OFF && held_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mnst_pkg::S_IDLE: begin
        if (accept) state_d = scan_en ? mnst_pkg::S_SCAN : mnst_pkg::S_DONE;
      end
      mnst_pkg::S_SCAN: begin
        if (last_idx) begin
          state_d = (op_q == mnst_pkg::OP_NOTE_ON) ? mnst_pkg::S_PLACE : mnst_pkg::S_DONE;
        end
      end
      mnst_pkg::S_PLACE: state_d = mnst_pkg::S_DONE;
      mnst_pkg::S_DONE: state_d = mnst_pkg::S_IDLE;
      default: state_d = mnst_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mnst_pkg::S_IDLE;
      sl_act_q     <= '0;
      sl_sus_q     <= '0;
      for (int k = 0; k < SOURCE_COUNT; k++) flags_q[k] <= '0;
      ptr_q        <= '0;
      idx_q        <= '0;
      free_idx_q   <= '0;
      free_found_q <= 1'b0;
      held_q       <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= 1'b0;
      unique case (state_q)
        mnst_pkg::S_IDLE: begin
          idx_q        <= '0;
          free_found_q <= 1'b0;
          if (accept) begin
            held_q <= flag_cur;
            if (op_i == mnst_pkg::OP_SUSTAIN && in_valid) begin
              flags_q[flag_src][flag_ch] <= pedal_down_i;
            end
            if (op_i == mnst_pkg::OP_CLEAR_SOURCE) begin
              for (int k = 0; k < SOURCE_COUNT; k++) begin
                if (source_num_i == 3'd0 || int'(source_num_i) == k + 1) begin
                  flags_q[k] <= '0;
                end
              end
              if (source_num_i == 3'd0) ptr_q <= '0;
            end
            if (op_i == mnst_pkg::OP_RESET_ALL) begin
              sl_act_q <= '0;
              sl_sus_q <= '0;
              for (int k = 0; k < SOURCE_COUNT; k++) flags_q[k] <= '0;
              ptr_q    <= '0;
            end
          end
        end
        mnst_pkg::S_SCAN: begin
          idx_q <= idx_q + SW'(1);
          if (hit) begin
            if (emit) begin
              sl_act_q[rd_idx] <= 1'b0;
              sl_sus_q[rd_idx] <= 1'b0;
            end else begin
              sl_sus_q[rd_idx] <= 1'b1;
            end
          end
          if (!free_found_q && (!sl_act_q[rd_idx] || emit)) begin
            free_found_q <= 1'b1;
            free_idx_q   <= rd_idx;
          end
          valid_q <= emit;
        end
        mnst_pkg::S_PLACE: begin
          if (free_found_q) begin
            sl_act_q[free_idx_q] <= 1'b1;
            sl_sus_q[free_idx_q] <= 1'b0;
          end else begin
            sl_sus_q[ptr_q] <= 1'b0;
            ptr_q   <= (ptr_q == SW'(SLOT_COUNT - 1)) ? '0 : ptr_q + SW'(1);
            valid_q <= 1'b1;
          end
        end
        mnst_pkg::S_DONE: valid_q <= 1'b1;
        default: valid_q <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_i;
      src_q  <= source_num_i;
      ch_q   <= channel_i;
      note_q <= note_i;
      pad_q  <= pad_voice_i;
      lead_q <= lead_voice_i;
      smp_q  <= sample_voice_i;
      own_q  <= owner_tag_i;
      tr_q   <= transient_flag_i;
    end
    if (state_q == mnst_pkg::S_PLACE) begin
      sl_tr_q[free_found_q ? free_idx_q : ptr_q]   <= tr_q;
      sl_src_q[free_found_q ? free_idx_q : ptr_q]  <= src_q;
      sl_ch_q[free_found_q ? free_idx_q : ptr_q]   <= ch_q;
      sl_note_q[free_found_q ? free_idx_q : ptr_q] <= note_q;
      sl_own_q[free_found_q ? free_idx_q : ptr_q]  <= own_q;
      sl_pad_q[free_found_q ? free_idx_q : ptr_q]  <= pad_q;
      sl_lead_q[free_found_q ? free_idx_q : ptr_q] <= lead_q;
      sl_smp_q[free_found_q ? free_idx_q : ptr_q]  <= smp_q;
    end
    if (state_q == mnst_pkg::S_DONE) begin
      kind_q     <= mnst_pkg::KIND_DONE;
      src_out_q  <= 3'd0;
      pad_out_q  <= 8'd0;
      lead_out_q <= 8'd0;
      smp_out_q  <= 8'd0;
      tr_out_q   <= 1'b0;
      last_q     <= 1'b1;
    end else begin
      kind_q     <= (state_q == mnst_pkg::S_PLACE) ? mnst_pkg::KIND_RELEASE : hit_kind;
      src_out_q  <= sl_src_q[rd_idx];
      pad_out_q  <= sl_pad_q[rd_idx];
      lead_out_q <= sl_lead_q[rd_idx];
      smp_out_q  <= sl_smp_q[rd_idx];
      tr_out_q   <= sl_tr_q[rd_idx];
      last_q     <= 1'b0;
    end
  end

  assign valid_o            = valid_q;
  assign kind_o             = kind_q;
  assign out_source_o       = src_out_q;
  assign out_pad_voice_o    = pad_out_q;
  assign out_lead_voice_o   = lead_out_q;
  assign out_sample_voice_o = smp_out_q;
  assign out_transient_o    = tr_out_q;
  assign last_o             = last_q;

endmodule
`default_nettype wire
